// ----- rtl/core/wla_pkg.sv -----
// wla_pkg: shared constants, types and slot helpers of the windowed latency average
// no dependencies; imported by wla_div, windowed_latency_average and wla_checker
`default_nettype none

package wla_pkg;

  // ring geometry
  parameter int QUEUE_LEN  = 64;
  parameter int SLOT_W     = $clog2(QUEUE_LEN);
  parameter int CNT_W      = SLOT_W;
  parameter int FILL_W     = $clog2(QUEUE_LEN + 1);

  // field widths
  parameter int SAMPLE_W   = 32;
  parameter int STAMP_W    = 64;
  parameter int PERIOD_W   = 32;
  parameter int AVG_W      = 32;
  parameter int COUNTED_W  = 6;
  parameter int ENTRY_W    = STAMP_W + SAMPLE_W;

  // divisor holds c(c+1)/2 or c, dividend the weighted or plain sum
  parameter int DIV_W      = 2 * CNT_W;
  parameter int SUM_W      = SAMPLE_W + DIV_W;
  parameter int ITER_W     = $clog2(SUM_W + 1);

  // configuration port
  parameter int CFG_IDX_W  = 1;
  parameter int CFG_DATA_W = 32;

  parameter logic [CFG_IDX_W-1:0] REG_AVERAGE_METHOD = 1'd0;
  parameter logic [CFG_IDX_W-1:0] REG_WINDOW_PERIOD  = 1'd1;

  parameter logic OP_INSERT = 1'b0;
  parameter logic OP_QUERY  = 1'b1;

  parameter logic METHOD_MEAN     = 1'b0;
  parameter logic METHOD_WEIGHTED = 1'b1;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    if (s == SLOT_W'(QUEUE_LEN - 1)) begin
      return '0;
    end
    return s + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    if (s == '0) begin
      return SLOT_W'(QUEUE_LEN - 1);
    end
    return s - 1'b1;
  endfunction

  // position of a slot in the write order: the last slot is written first after reset
  function automatic logic [FILL_W-1:0] slot_order(input logic [SLOT_W-1:0] s);
    if (s == SLOT_W'(QUEUE_LEN - 1)) begin
      return '0;
    end
    return FILL_W'(s) + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/wla_ram.sv -----
// wla_ram: generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module wla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/wla_div.sv -----
// wla_div: restoring divider, one quotient bit per cycle
// depends on wla_pkg (widths, request and response structs)
`default_nettype none

module wla_div import wla_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] iter_r;
  logic [SUM_W-1:0]  quo_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  divisor_r;

  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[SUM_W-1]};
    ge      = rem_sh >= {1'b0, divisor_r};
    rem_sub = rem_sh - {1'b0, divisor_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= busy_r && (iter_r == ITER_W'(1));
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        iter_r <= ITER_W'(SUM_W);
      end else if (busy_r) begin
        iter_r <= iter_r - 1'b1;
        if (iter_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      quo_r     <= req.dividend;
      rem_r     <= '0;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/core/windowed_latency_average.sv -----
// windowed_latency_average: top level, ring control, window walk and accumulation
// depends on wla_pkg, wla_ram and wla_div
`default_nettype none

// Keeps the last QUEUE_LEN-1 latency samples with their insert time in one
// ring ram and answers the windowed mean or linearly weighted mean on a query.
// Inserts may follow each other in every cycle while no query is in progress.
// A query walks the ring through the single ram read port, one entry per
// cycle, then runs a bit-serial divider, one quotient bit per cycle. When
// nothing is counted the divider is skipped. The next item is taken in the
// cycle after the result is loaded, and a stalled output register holds the
// next result back for as long as it stays stalled.
// in_stall is high from a query's acceptance until its result is loaded into
// the output register. Entries never written read as zero via a fill count,
// so no clearing pass is needed after reset.
module windowed_latency_average import wla_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_op,
  input  wire logic [SAMPLE_W-1:0]   in_sample_msec,
  input  wire logic [STAMP_W-1:0]    in_now_msec,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [AVG_W-1:0]      out_average_msec,
  output logic      [COUNTED_W-1:0]  out_counted,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WALK = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;

  logic                method_r;
  logic [PERIOD_W-1:0] period_r;

  logic [SLOT_W-1:0]   oldest_r;
  logic [FILL_W-1:0]   fill_r;
  logic [SLOT_W-1:0]   spare_slot;
  logic [SLOT_W-1:0]   newest_slot;

  logic                accept;
  logic                do_insert;
  logic                do_query;

  logic [STAMP_W-1:0]  cutoff_r;
  logic [STAMP_W-1:0]  cutoff_nxt;
  logic [SLOT_W-1:0]   rd_slot_r;
  logic [CNT_W-1:0]    left_r;
  logic                issue;

  logic [ENTRY_W-1:0]  rd_data;
  logic                p1_v_r;
  logic                p1_wr_r;
  logic [STAMP_W-1:0]  p1_stamp;
  logic [SAMPLE_W-1:0] p1_sample;
  logic                hit;

  logic                p2_v_r;
  logic [SAMPLE_W-1:0] p2_sample_r;
  logic                w_pend_r;

  logic [SUM_W-1:0]    acc_r;
  logic [SUM_W-1:0]    wsum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                walk_done;

  logic [CNT_W:0]      cnt_p1;
  logic [2*CNT_W:0]    tri_prod;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [AVG_W-1:0]    res_avg_r;
  logic                out_free;
  logic                out_valid_r;
  logic [AVG_W-1:0]    out_avg_r;
  logic [COUNTED_W-1:0] out_cnt_r;
  logic [CNT_W+COUNTED_W-1:0] cnt_ext;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= METHOD_MEAN;
      period_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AVERAGE_METHOD: method_r <= cfg_wdata[0];
        REG_WINDOW_PERIOD:  period_r <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign do_insert = accept && (in_op == OP_INSERT);
  assign do_query  = accept && (in_op == OP_QUERY);

  assign spare_slot  = slot_dec(oldest_r);
  assign newest_slot = slot_dec(spare_slot);
  assign cutoff_nxt  = (period_r != '0) ?
                       in_now_msec - {(STAMP_W-PERIOD_W)'(0), period_r} : '0;

  // ring pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      fill_r   <= '0;
    end else if (do_insert) begin
      oldest_r <= slot_inc(oldest_r);
      if (fill_r != FILL_W'(QUEUE_LEN)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  assign issue = (state_r == ST_WALK) && (left_r != '0);

  wla_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_LEN)
  ) u_ram (
    .clk    (clk),
    .wr_en  (do_insert),
    .wr_addr(spare_slot),
    .wr_data({in_now_msec, in_sample_msec}),
    .rd_en  (issue),
    .rd_addr(rd_slot_r),
    .rd_data(rd_data)
  );

  // walk newest to oldest so the running sum folds into the weighted sum
  assign p1_stamp  = p1_wr_r ? rd_data[ENTRY_W-1 -: STAMP_W] : '0;
  assign p1_sample = p1_wr_r ? rd_data[SAMPLE_W-1:0] : '0;
  assign hit       = p1_v_r && (cutoff_r < p1_stamp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r   <= 1'b0;
      p2_v_r   <= 1'b0;
      w_pend_r <= 1'b0;
      left_r   <= '0;
    end else begin
      p1_v_r   <= issue;
      p2_v_r   <= hit;
      w_pend_r <= p2_v_r;
      if (do_query) begin
        left_r <= CNT_W'(QUEUE_LEN - 1);
      end else if (issue) begin
        left_r <= left_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_wr_r     <= fill_r > slot_order(rd_slot_r);
    p2_sample_r <= p1_sample;
    if (do_query) begin
      cutoff_r  <= cutoff_nxt;
      rd_slot_r <= newest_slot;
      acc_r     <= '0;
      wsum_r    <= '0;
      cnt_r     <= '0;
    end else begin
      if (issue) begin
        rd_slot_r <= slot_dec(rd_slot_r);
      end
      if (p2_v_r) begin
        acc_r <= acc_r + SUM_W'(p2_sample_r);
        cnt_r <= cnt_r + 1'b1;
      end
      // weighted sum adds the running sum once per counted entry
      if (w_pend_r) begin
        wsum_r <= wsum_r + acc_r;
      end
    end
  end

  assign walk_done = (left_r == '0) && !p1_v_r && !p2_v_r && !w_pend_r;

  // divisor c(c+1)/2 for the weighted mean
  assign cnt_p1   = {1'b0, cnt_r} + 1'b1;
  assign tri_prod = (2*CNT_W+1)'(cnt_r) * (2*CNT_W+1)'(cnt_p1);

  always_comb begin
    div_req.start    = (state_r == ST_PREP) && (cnt_r != '0);
    div_req.dividend = (method_r == METHOD_WEIGHTED) ? wsum_r : acc_r;
    div_req.divisor  = (method_r == METHOD_WEIGHTED) ? tri_prod[2*CNT_W:1]
                                                     : {CNT_W'(0), cnt_r};
  end

  wla_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (do_query) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (walk_done) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        state_nxt = (cnt_r != '0) ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_rsp.done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      res_avg_r <= '0;
    end else if ((state_r == ST_DIV) && div_rsp.done) begin
      res_avg_r <= div_rsp.quotient[AVG_W-1:0];
    end
  end

  // output register
  assign cnt_ext = {COUNTED_W'(0), cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_avg_r <= res_avg_r;
      out_cnt_r <= cnt_ext[COUNTED_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_average_msec = out_avg_r;
  assign out_counted      = out_cnt_r;

endmodule

`default_nettype wire

// ----- rtl/core/wla_checker.sv -----
// wla_checker: port-level assertions on windowed_latency_average, with its bind
// depends on wla_pkg (op codes and widths)
`default_nettype none

module wla_checker import wla_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  in_op,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [AVG_W-1:0]      out_average_msec,
  input wire logic [COUNTED_W-1:0]  out_counted
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an empty window always averages to zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_counted == '0) |-> (out_average_msec == '0))
    else $error("nonzero average with nothing counted");

  // a query holds off the next item while it walks the ring
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == OP_QUERY) |=> in_stall)
    else $error("item taken during a query walk");

  // an insert never stalls the item after it
  a_insert_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == OP_INSERT) |=> !in_stall)
    else $error("stall after an insert");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_average_msec)
                               && $stable(out_counted))
    else $error("stalled result changed");

endmodule

bind windowed_latency_average wla_checker u_wla_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_op           (in_op),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_average_msec(out_average_msec),
  .out_counted     (out_counted)
);

`default_nettype wire
